@@ src/cse_pkg.sv @@
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types, codes and saturation helper for the cubic spline evaluator.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] FLAG_INSIDE = 2'd0;
  localparam logic [1:0] FLAG_LEFT   = 2'd1;
  localparam logic [1:0] FLAG_RIGHT  = 2'd2;

  localparam logic signed [47:0] POS_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] NEG_MIN = {1'b1, {47{1'b0}}};

  // Horner micro-operations, issued in this order
  typedef enum logic [2:0] {
    OP_V1 = 3'd0,
    OP_V2 = 3'd1,
    OP_V3 = 3'd2,
    OP_F1 = 3'd3,
    OP_F2 = 3'd4,
    OP_S  = 3'd5
  } op_t;

  typedef struct packed {
    logic cap_query;
    logic cap_coef;
    logic cap_abs;
    logic ph_load;
    logic ph_lo;
    logic ph_hi;
    logic ph_rnd;
    logic ph_acc;
    logic out_load;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic t_lt;
    logic t_gt;
    logic out_busy;
  } dp_status_t;

  // Clamp to the signed 48-bit range
  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    if (x > 64'sh0000_7FFF_FFFF_FFFF) begin
      return POS_MAX;
    end else if (x < -64'sh0000_8000_0000_0000) begin
      return NEG_MIN;
    end
    return x[47:0];
  endfunction

endpackage

@@ src/cse_ram.sv @@
// ----------------------------------------------------------------------------
// cse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/cse_ctrl.sv @@
// ----------------------------------------------------------------------------
// cse_ctrl
// Controller: segment search over the knot store and Horner op sequencing.
// ----------------------------------------------------------------------------
module cse_ctrl #(
  parameter int MAX_KNOTS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [6:0]                   cfg_knots_in_use,
  input  logic                         in_valid,
  input  logic                         in_cmd,
  output logic                         in_stall,
  input  cse_pkg::dp_status_t          status,
  output cse_pkg::dp_cmd_t             cmd,
  output logic [$clog2(MAX_KNOTS)-1:0] rd_addr,
  output logic [$clog2(MAX_KNOTS)-1:0] seg,
  output logic [1:0]                   flag
);
  import cse_pkg::*;

  localparam int AW = $clog2(MAX_KNOTS);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_RD0  = 15'h0002,
    S_RDN  = 15'h0004,
    S_CHKN = 15'h0008,
    S_SCAN = 15'h0010,
    S_SCHK = 15'h0020,
    S_COEF = 15'h0040,
    S_DT   = 15'h0080,
    S_ABS  = 15'h0100,
    S_LOAD = 15'h0200,
    S_LO   = 15'h0400,
    S_HI   = 15'h0800,
    S_RND  = 15'h1000,
    S_ACC  = 15'h2000,
    S_OUT  = 15'h4000
  } state_t;

  state_t         state_r, state_nxt;
  op_t            op_r, op_nxt;
  logic [6:0]     knots_r;
  logic [AW-1:0]  nm1_r, nm1_nxt, nm2_r, nm2_nxt;
  logic [AW-1:0]  idx_r, idx_nxt, scan_r, scan_nxt;
  logic [1:0]     flag_r, flag_nxt;
  logic           lt0_r, lt0_nxt;
  logic [12:0]    k_ext, n_c;
  logic           q_acc;

  // Clamp the knot count into the supported range
  always_comb begin
    k_ext = {6'd0, knots_r};
    if (k_ext < 13'd2) begin
      n_c = 13'd2;
    end else if (k_ext > 13'(MAX_KNOTS)) begin
      n_c = 13'(MAX_KNOTS);
    end else begin
      n_c = k_ext;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign q_acc    = in_valid && !in_stall && (in_cmd == CMD_QUERY);

  // Next state and search bookkeeping
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    nm1_nxt   = nm1_r;
    nm2_nxt   = nm2_r;
    idx_nxt   = idx_r;
    scan_nxt  = scan_r;
    flag_nxt  = flag_r;
    lt0_nxt   = lt0_r;
    cmd       = '0;
    cmd.op    = op_r;
    rd_addr   = '0;
    case (state_r)
      S_IDLE: begin
        if (q_acc) begin
          cmd.cap_query = 1'b1;
          nm1_nxt       = AW'(n_c - 13'd1);
          nm2_nxt       = AW'(n_c - 13'd2);
          state_nxt     = S_RD0;
        end
      end
      S_RD0: begin
        rd_addr   = '0;
        state_nxt = S_RDN;
      end
      S_RDN: begin
        rd_addr   = nm1_r;
        lt0_nxt   = status.t_lt;
        state_nxt = S_CHKN;
      end
      S_CHKN: begin
        if (lt0_r) begin
          idx_nxt   = '0;
          flag_nxt  = FLAG_LEFT;
          state_nxt = S_COEF;
        end else if (!status.t_lt) begin
          idx_nxt   = nm2_r;
          flag_nxt  = status.t_gt ? FLAG_RIGHT : FLAG_INSIDE;
          state_nxt = S_COEF;
        end else begin
          scan_nxt  = nm2_r;
          flag_nxt  = FLAG_INSIDE;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr   = scan_r;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        // Walk down until a knot is not above the query or knot 0 is reached
        if (!status.t_lt || (scan_r == '0)) begin
          idx_nxt   = scan_r;
          state_nxt = S_COEF;
        end else begin
          scan_nxt  = scan_r - AW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_COEF: begin
        rd_addr   = idx_r;
        state_nxt = S_DT;
      end
      S_DT: begin
        cmd.cap_coef = 1'b1;
        state_nxt    = S_ABS;
      end
      S_ABS: begin
        cmd.cap_abs = 1'b1;
        op_nxt      = OP_V1;
        state_nxt   = S_LOAD;
      end
      S_LOAD: begin
        cmd.ph_load = 1'b1;
        state_nxt   = S_LO;
      end
      S_LO: begin
        cmd.ph_lo = 1'b1;
        state_nxt = S_HI;
      end
      S_HI: begin
        cmd.ph_hi = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.ph_rnd = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.ph_acc = 1'b1;
        if (op_r == OP_S) begin
          state_nxt = S_OUT;
        end else begin
          op_nxt    = op_t'(op_r + 3'd1);
          state_nxt = S_LOAD;
        end
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign seg  = idx_r;
  assign flag = flag_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_V1;
      knots_r <= 7'd2;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (cfg_wr_en) begin
        knots_r <= cfg_knots_in_use;
      end
    end
  end

  // Search registers
  always_ff @(posedge clk) begin
    nm1_r  <= nm1_nxt;
    nm2_r  <= nm2_nxt;
    idx_r  <= idx_nxt;
    scan_r <= scan_nxt;
    flag_r <= flag_nxt;
    lt0_r  <= lt0_nxt;
  end

endmodule

@@ src/cse_dp.sv @@
// ----------------------------------------------------------------------------
// cse_dp
// Datapath: offset, shared split multiplier, rounding, saturating adds and
// the output register.
// ----------------------------------------------------------------------------
module cse_dp #(
  parameter int AW = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cse_pkg::dp_cmd_t          cmd,
  output cse_pkg::dp_status_t       status,
  input  logic [AW-1:0]             seg,
  input  logic [1:0]                flag,
  input  logic signed [31:0]        in_query_pos,
  input  logic signed [31:0]        rd_knot,
  input  logic signed [47:0]        rd_const,
  input  logic signed [47:0]        rd_lin,
  input  logic signed [47:0]        rd_quad,
  input  logic signed [47:0]        rd_cubic,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [47:0]        out_spline_value,
  output logic signed [47:0]        out_first_deriv,
  output logic signed [47:0]        out_second_deriv,
  output logic [5:0]                out_segment_used,
  output logic [1:0]                out_extrapolated
);
  import cse_pkg::*;

  logic signed [31:0] t_r;
  logic signed [47:0] a_r, b_r, c_r, d_r;
  logic signed [47:0] c2_r, d3_r, d6_r;
  logic signed [32:0] dt_r;
  logic [32:0]        ad_r;
  logic               dneg_r, neg_r;
  logic [47:0]        ap_r;
  logic [80:0]        acc_r;
  logic signed [47:0] m_r, v_r, f_r, s_r;
  logic               out_valid_r;

  logic signed [47:0] p_sel, add_sel;
  logic [56:0]        lo_prod, hi_prod;
  logic [80:0]        rnd_sum;
  logic [64:0]        r_mag;
  logic               r_big;
  logic signed [48:0] acc_sum;
  logic signed [47:0] acc_sat;
  logic signed [51:0] d_ext;

  assign status.t_lt     = (t_r < rd_knot);
  assign status.t_gt     = (t_r > rd_knot);
  assign status.out_busy = out_valid_r && out_stall;

  // Operand and addend select per op
  always_comb begin
    case (cmd.op)
      OP_V1:   begin p_sel = d_r;  add_sel = c_r;  end
      OP_V2:   begin p_sel = v_r;  add_sel = b_r;  end
      OP_V3:   begin p_sel = v_r;  add_sel = a_r;  end
      OP_F1:   begin p_sel = d3_r; add_sel = c2_r; end
      OP_F2:   begin p_sel = f_r;  add_sel = b_r;  end
      OP_S:    begin p_sel = d6_r; add_sel = c2_r; end
      default: begin p_sel = '0;   add_sel = '0;   end
    endcase
  end

  assign d_ext   = 52'(d_r);
  assign lo_prod = ap_r[23:0] * ad_r;
  assign hi_prod = ap_r[47:24] * ad_r;

  // Round half away from zero on the magnitude, then saturate
  assign rnd_sum = acc_r + 81'h8000;
  assign r_mag   = rnd_sum[80:16];
  assign r_big   = |r_mag[64:47];
  assign acc_sum = 49'(add_sel) + 49'(m_r);
  assign acc_sat = sat48(64'(acc_sum));

  // Arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.cap_query) begin
      t_r <= in_query_pos;
    end
    if (cmd.cap_coef) begin
      a_r  <= rd_const;
      b_r  <= rd_lin;
      c_r  <= rd_quad;
      d_r  <= rd_cubic;
      dt_r <= 33'(t_r) - 33'(rd_knot);
    end
    if (cmd.cap_abs) begin
      dneg_r <= dt_r[32];
      ad_r   <= dt_r[32] ? 33'(-dt_r) : 33'(dt_r);
      c2_r   <= sat48(64'(49'(c_r) + 49'(c_r)));
      d3_r   <= sat48(64'(d_ext + d_ext + d_ext));
      d6_r   <= sat48(64'((d_ext <<< 2) + (d_ext <<< 1)));
    end
    if (cmd.ph_load) begin
      neg_r <= p_sel[47] ^ dneg_r;
      ap_r  <= p_sel[47] ? 48'(-p_sel) : 48'(p_sel);
    end
    if (cmd.ph_lo) begin
      acc_r <= 81'(lo_prod);
    end
    if (cmd.ph_hi) begin
      acc_r <= acc_r + {hi_prod, 24'd0};
    end
    if (cmd.ph_rnd) begin
      if (neg_r) begin
        m_r <= r_big ? NEG_MIN : -$signed(r_mag[47:0]);
      end else begin
        m_r <= r_big ? POS_MAX : $signed(r_mag[47:0]);
      end
    end
    if (cmd.ph_acc) begin
      case (cmd.op)
        OP_V1, OP_V2, OP_V3: v_r <= acc_sat;
        OP_F1, OP_F2:        f_r <= acc_sat;
        OP_S:                s_r <= acc_sat;
        default:             s_r <= s_r;
      endcase
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_spline_value <= v_r;
      out_first_deriv  <= f_r;
      out_second_deriv <= s_r;
      out_segment_used <= 6'(seg);
      out_extrapolated <= flag;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ src/cubic_spline_evaluator.sv @@
// Query sequence: read knot 0 and the last knot; scan downward for the segment only
// when the query is inside (not left of the first knot, nor at or past the last);
// read its coefficients; run six Horner steps on one shared 24x33 split multiplier.
// Loads leave the block idle; one query is in flight at a time.
// Reset: synchronous active low; knot count returns to 2, no result pending;
// the coefficient stores are not cleared.
// ----------------------------------------------------------------------------
// cubic_spline_evaluator
// Piecewise cubic spline evaluation over a loadable knot/coefficient table.
// ----------------------------------------------------------------------------
module cubic_spline_evaluator #(
  parameter int MAX_KNOTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_knots_in_use,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_knot_value,
  input  logic signed [47:0] in_coef_const,
  input  logic signed [47:0] in_coef_lin,
  input  logic signed [47:0] in_coef_quad,
  input  logic signed [47:0] in_coef_cubic,
  input  logic signed [31:0] in_query_pos,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_spline_value,
  output logic signed [47:0] out_first_deriv,
  output logic signed [47:0] out_second_deriv,
  output logic [5:0]         out_segment_used,
  output logic [1:0]         out_extrapolated
);
  import cse_pkg::*;

  localparam int AW = $clog2(MAX_KNOTS);

  dp_cmd_t            cmd;
  dp_status_t         status;
  logic [AW-1:0]      rd_addr, seg, wr_addr;
  logic [1:0]         flag;
  logic               wr_en;
  logic signed [31:0] rd_knot;
  logic signed [47:0] rd_const, rd_lin, rd_quad, rd_cubic;

  // Store a load transaction; drop entries beyond the table
  assign wr_en   = in_valid && !in_stall && (in_cmd == CMD_LOAD) &&
                   ({7'd0, in_entry_index} < 13'(MAX_KNOTS));
  assign wr_addr = AW'(in_entry_index);

  cse_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knot_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(in_knot_value),
    .raddr(rd_addr), .rdata(rd_knot)
  );
  cse_ram #(.WIDTH(48), .DEPTH(MAX_KNOTS)) u_const_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(in_coef_const),
    .raddr(rd_addr), .rdata(rd_const)
  );
  cse_ram #(.WIDTH(48), .DEPTH(MAX_KNOTS)) u_lin_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(in_coef_lin),
    .raddr(rd_addr), .rdata(rd_lin)
  );
  cse_ram #(.WIDTH(48), .DEPTH(MAX_KNOTS)) u_quad_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(in_coef_quad),
    .raddr(rd_addr), .rdata(rd_quad)
  );
  cse_ram #(.WIDTH(48), .DEPTH(MAX_KNOTS)) u_cubic_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(in_coef_cubic),
    .raddr(rd_addr), .rdata(rd_cubic)
  );

  cse_ctrl #(.MAX_KNOTS(MAX_KNOTS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_knots_in_use(cfg_knots_in_use),
    .in_valid(in_valid), .in_cmd(in_cmd), .in_stall(in_stall),
    .status(status), .cmd(cmd), .rd_addr(rd_addr), .seg(seg), .flag(flag)
  );

  cse_dp #(.AW(AW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .seg(seg), .flag(flag), .in_query_pos(in_query_pos),
    .rd_knot(rd_knot), .rd_const(rd_const), .rd_lin(rd_lin),
    .rd_quad(rd_quad), .rd_cubic(rd_cubic),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_spline_value(out_spline_value), .out_first_deriv(out_first_deriv),
    .out_second_deriv(out_second_deriv), .out_segment_used(out_segment_used),
    .out_extrapolated(out_extrapolated)
  );

endmodule

@@ src/cse_chk.sv @@
// ----------------------------------------------------------------------------
// cse_chk
// Port-level checks for the spline evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module cse_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_cmd,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [47:0] out_spline_value,
  input logic [5:0]         out_segment_used,
  input logic [1:0]         out_extrapolated
);
  import cse_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_spline_value))
    else $error("stalled result dropped or changed");

  // Drop any result on reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Busy after a query transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_cmd == CMD_QUERY) |=> in_stall)
    else $error("query not held busy");

  // Left extrapolation always uses the first segment
  a_left_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_extrapolated == FLAG_LEFT) |-> out_segment_used == 6'd0)
    else $error("left extrapolation with non-zero segment");

  // Flag carries only defined codes
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_extrapolated == FLAG_INSIDE) ||
                  (out_extrapolated == FLAG_LEFT) ||
                  (out_extrapolated == FLAG_RIGHT))
    else $error("undefined extrapolation code");

endmodule

bind cubic_spline_evaluator cse_chk u_cse_chk (.*);
